FILE: hdl/accelerometer_register_slave_unit_macros.svh
// Assertion macros shared by the checker of the accelerometer register slave.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ACCELEROMETER_REGISTER_SLAVE_UNIT_MACROS_SVH
`define ACCELEROMETER_REGISTER_SLAVE_UNIT_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle
`define ARS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define ARS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/ars_pkg.sv
// Shared types, constants and pointer rules of the accelerometer register slave.
// Used by the controller, the datapath and the top level; depends on nothing.
package ars_pkg;

  localparam int REG_WORDS = 256;
  localparam int ADDR_W    = 8;
  localparam int BYTE_W    = 8;

  // Register addresses with special behaviour
  localparam logic [ADDR_W-1:0] ADDR_STATUS    = 8'h00;
  localparam logic [ADDR_W-1:0] ADDR_OUT_X_MSB = 8'h01;
  localparam logic [ADDR_W-1:0] ADDR_OUT_X_LSB = 8'h02;
  localparam logic [ADDR_W-1:0] ADDR_OUT_Y_MSB = 8'h03;
  localparam logic [ADDR_W-1:0] ADDR_OUT_Y_LSB = 8'h04;
  localparam logic [ADDR_W-1:0] ADDR_OUT_Z_MSB = 8'h05;
  localparam logic [ADDR_W-1:0] ADDR_OUT_Z_LSB = 8'h06;
  localparam logic [ADDR_W-1:0] ADDR_F_SETUP   = 8'h09;
  localparam logic [ADDR_W-1:0] ADDR_IDENTITY  = 8'h0D;
  localparam logic [ADDR_W-1:0] ADDR_PL_STATUS = 8'h10;
  localparam logic [ADDR_W-1:0] ADDR_PL_CFG    = 8'h11;
  localparam logic [ADDR_W-1:0] ADDR_PL_BF_ZC  = 8'h13;
  localparam logic [ADDR_W-1:0] ADDR_PL_THS    = 8'h14;
  localparam logic [ADDR_W-1:0] ADDR_PULSE_SRC = 8'h22;
  localparam logic [ADDR_W-1:0] ADDR_CTRL_REG1 = 8'h2A;
  localparam logic [ADDR_W-1:0] ADDR_WRAP_LOW  = 8'h31;
  localparam logic [ADDR_W-1:0] ADDR_WRAP_HIGH = 8'hFF;
  localparam logic [ADDR_W-1:0] ADDR_HIGH_BASE = 8'h81;

  // Stock reset contents
  localparam logic [BYTE_W-1:0] RST_IDENTITY  = 8'h1A;
  localparam logic [BYTE_W-1:0] RST_PL_CFG    = 8'h80;
  localparam logic [BYTE_W-1:0] RST_PL_BF_ZC  = 8'h44;
  localparam logic [BYTE_W-1:0] RST_PL_THS    = 8'h84;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Reset value of a register
  function automatic logic [BYTE_W-1:0] stock_value(input logic [ADDR_W-1:0] addr);
    logic [BYTE_W-1:0] v;
    v = '0;
    case (addr)
      ADDR_IDENTITY: v = RST_IDENTITY;
      ADDR_PL_CFG:   v = RST_PL_CFG;
      ADDR_PL_BF_ZC: v = RST_PL_BF_ZC;
      ADDR_PL_THS:   v = RST_PL_THS;
      default:       v = '0;
    endcase
    return v;
  endfunction

  // Pointer advance after a stored write byte or a read
  function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p,
                                                 input logic fast,
                                                 input logic fifo);
    logic [ADDR_W-1:0] n;
    n = p + 1'b1;
    case (p)
      ADDR_OUT_X_MSB: n = fifo ? ADDR_OUT_X_MSB : (fast ? ADDR_OUT_Y_MSB : ADDR_OUT_X_LSB);
      ADDR_OUT_X_LSB, ADDR_OUT_Y_LSB, ADDR_OUT_Z_MSB: n = fast ? ADDR_STATUS : p + 1'b1;
      ADDR_OUT_Y_MSB: n = !fast ? ADDR_OUT_Y_LSB : (fifo ? ADDR_STATUS : ADDR_OUT_Z_MSB);
      ADDR_OUT_Z_LSB: n = ADDR_STATUS;
      ADDR_WRAP_LOW:  n = ADDR_IDENTITY;
      ADDR_WRAP_HIGH: n = ADDR_HIGH_BASE;
      default: n = p + 1'b1;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/ars_datapath.sv
// Datapath of the accelerometer register slave: register memory, pointer,
// bus flags, interrupt level and result register. Depends on ars_pkg.
module ars_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  ars_pkg::ctrl_cmd_t     ctrl,
  output ars_pkg::dp_status_t    status,
  input  logic [1:0]             cmd_in,
  input  logic [7:0]             data_in,
  input  logic [7:0]             local_addr_in,
  input  logic                   raise_irq_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             read_data,
  output logic [7:0]             pointer,
  output logic                   irq_line,
  output logic                   read_flag
);
  import ars_pkg::*;

  // Captured transaction
  cmd_t              cmd_q;
  logic [BYTE_W-1:0] data_q;
  logic [ADDR_W-1:0] laddr_q;
  logic              raise_q;

  // Register memory with written marks
  logic [BYTE_W-1:0] mem [REG_WORDS];
  logic [REG_WORDS-1:0] written;
  logic [BYTE_W-1:0] rd_mem_q;
  logic              rd_written_q;

  // Architectural state
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic              taken, taken_next;
  logic              top_flag, top_flag_next;
  logic              irq, irq_next;
  logic              fast, fast_next;
  logic              fifo, fifo_next;

  // Write port
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] rd_val, rd_out;

  assign status.out_free = !out_valid || out_ready;

  // Capture transaction and read the byte at the pointer
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q        <= cmd_t'(cmd_in);
      data_q       <= data_in;
      laddr_q      <= local_addr_in;
      raise_q      <= raise_irq_in;
      rd_mem_q     <= mem[ptr];
      rd_written_q <= written[ptr];
    end
  end

  assign rd_val = rd_written_q ? rd_mem_q : stock_value(ptr);

  // Work out the effect of the captured transaction
  always_comb begin
    ptr_next      = ptr;
    taken_next    = taken;
    top_flag_next = top_flag;
    irq_next      = irq;
    fast_next     = fast;
    fifo_next     = fifo;
    we            = 1'b0;
    waddr         = ptr;
    wdata         = data_q;
    rd_out        = '0;
    case (cmd_q)
      CMD_WRITE: begin
        if (!taken) begin
          ptr_next      = data_q;
          top_flag_next = data_q[BYTE_W-1];
          taken_next    = 1'b1;
        end else begin
          we = 1'b1;
          if (ptr == ADDR_CTRL_REG1) fast_next = data_q[1];
          if (ptr == ADDR_F_SETUP)   fifo_next = &data_q[7:6];
          ptr_next = next_ptr(ptr, fast_next, fifo_next);
        end
      end
      CMD_READ: begin
        rd_out = rd_val;
        if (ptr == ADDR_PULSE_SRC) irq_next = 1'b0;
        if (ptr == ADDR_PULSE_SRC || ptr == ADDR_PL_STATUS || ptr == ADDR_STATUS) begin
          we    = 1'b1;
          wdata = '0;
        end
        ptr_next = next_ptr(ptr, fast, fifo);
      end
      CMD_STOP: begin
        taken_next    = 1'b0;
        top_flag_next = 1'b0;
      end
      default: begin
        we    = 1'b1;
        waddr = laddr_q;
        if (laddr_q == ADDR_CTRL_REG1) fast_next = data_q[1];
        if (laddr_q == ADDR_F_SETUP)   fifo_next = &data_q[7:6];
        if (raise_q) irq_next = 1'b1;
      end
    endcase
  end

  // Memory write
  always_ff @(posedge clk) begin
    if (ctrl.execute && we) begin
      mem[waddr] <= wdata;
    end
  end

  // Control state and written marks
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      taken    <= 1'b0;
      top_flag <= 1'b0;
      irq      <= 1'b0;
      fast     <= 1'b0;
      fifo     <= 1'b0;
      written  <= '0;
    end else if (ctrl.execute) begin
      ptr      <= ptr_next;
      taken    <= taken_next;
      top_flag <= top_flag_next;
      irq      <= irq_next;
      fast     <= fast_next;
      fifo     <= fifo_next;
      if (we) written[waddr] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      read_data <= rd_out;
      pointer   <= ptr_next;
      irq_line  <= irq_next;
      read_flag <= top_flag_next;
    end
  end

endmodule

FILE: hdl/ars_ctrl.sv
// Controller of the accelerometer register slave: capture, then execute
// once the result register is free. Depends on ars_pkg.
module ars_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ars_pkg::dp_status_t status,
  output ars_pkg::ctrl_cmd_t  ctrl
);
  import ars_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready     = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.execute = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        ctrl.capture = in_valid;
      end
      ST_EXEC: ctrl.execute = status.out_free;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

FILE: hdl/accelerometer_register_slave_unit.sv
// Accelerometer register slave: bus-side register file with auto-increment.
// Each transaction is captured in ST_IDLE and executed in ST_EXEC; m_tvalid rises with execute.
// A new transaction is accepted only after the last one has executed (capture with memory read, then
// execute with memory write); a stalled result holds the execute step.
// Reset (rst, synchronous): pointer, flags, interrupt and output valid clear;
// the register file reads its stock values at once through per-entry marks.
module accelerometer_register_slave_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] data, [15:8] local_addr, [16] raise_irq
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [7:0] read_data, [15:8] pointer, [16] irq_line,
                                 // [17] read_flag
);
  import ars_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;
  logic [7:0] read_data, pointer;
  logic       irq_line, read_flag;

  ars_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  ars_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .cmd_in        (s_tuser),
    .data_in       (s_tdata[7:0]),
    .local_addr_in (s_tdata[15:8]),
    .raise_irq_in  (s_tdata[16]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .read_data     (read_data),
    .pointer       (pointer),
    .irq_line      (irq_line),
    .read_flag     (read_flag)
  );

  // Pack the result
  assign m_tdata = {6'd0, read_flag, irq_line, pointer, read_data};

endmodule

FILE: hdl/ars_checker.sv
// Port-level checker for the accelerometer register slave, bound to the top.
// Depends on the assertion macro header and on ars_pkg for the command codes.
`include "accelerometer_register_slave_unit_macros.svh"

module ars_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import ars_pkg::*;

  logic in_non_read;

  // Accepted transaction that is not a read
  assign in_non_read = s_tvalid && s_tready && (s_tuser != CMD_READ);

  // Stalled result holds
  `ARS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // One transaction in work at a time
  `ARS_ASSERT_NEXT(a_one_in_work, clk, rst, s_tvalid && s_tready, !s_tready)

  // Padding bits of the result stay zero
  `ARS_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[23:18] == 6'd0)

  // A non-read transaction returns no read byte
  `ARS_ASSERT_NOW(a_rd_zero, clk, rst, $rose(m_tvalid) && $past(in_non_read, 2), m_tdata[7:0] == '0)

endmodule

bind accelerometer_register_slave_unit ars_checker u_chk (.*);
